// File: rtl/core/sket_pkg.sv
// Types and constants shared by the sparse kernel eligibility table.
package sket_pkg;

  localparam int DIM_W     = 16;
  localparam int BUCKET_W  = 16;
  localparam int CODE_W    = 8;
  localparam int LIMIT_W   = 8;
  localparam int KEY_W     = 3 * BUCKET_W + 2 * CODE_W;
  localparam int PROD_MN_W = 2 * DIM_W;
  localparam int PROD_W    = 3 * DIM_W;
  localparam int FLOPS_W   = PROD_W + 1;
  localparam int OPCODE_W  = 2;
  localparam int REASON_W  = 3;
  localparam int CFG_IDX_W = 2;

  typedef logic [OPCODE_W-1:0]  opcode_t;
  typedef logic [REASON_W-1:0]  reason_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [KEY_W-1:0]     key_t;

  localparam opcode_t OP_CHECK  = 2'd0;
  localparam opcode_t OP_RECORD = 2'd1;
  localparam opcode_t OP_CLEAR  = 2'd2;

  localparam reason_t REASON_OK             = 3'd0;
  localparam reason_t REASON_WRONG_SPARSITY = 3'd1;
  localparam reason_t REASON_TOO_SMALL      = 3'd2;
  localparam reason_t REASON_BLACKLISTED    = 3'd3;
  localparam reason_t REASON_NO_COMPRESSION = 3'd4;

  localparam cfg_idx_t CFG_MIN_FLOPS     = 2'd0;
  localparam cfg_idx_t CFG_FAILURE_LIMIT = 2'd1;
  localparam cfg_idx_t CFG_TWO_FOUR_CODE = 2'd2;

  localparam logic [FLOPS_W-1:0] MIN_FLOPS_RESET     = 49'd1048576;
  localparam logic [LIMIT_W-1:0] FAILURE_LIMIT_RESET = 8'd3;
  localparam logic [CODE_W-1:0]  TWO_FOUR_CODE_RESET = 8'd1;

endpackage

// File: rtl/core/sket_if.sv
// Request, response and configuration channels of the eligibility table.
interface sket_req_if;
  import sket_pkg::*;
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [DIM_W-1:0]    dim_m;
  logic [DIM_W-1:0]    dim_n;
  logic [DIM_W-1:0]    dim_k;
  logic [CODE_W-1:0]   job_sparsity;
  logic [BUCKET_W-1:0] bucket_m;
  logic [BUCKET_W-1:0] bucket_n;
  logic [BUCKET_W-1:0] bucket_k;
  logic [CODE_W-1:0]   key_dtype;
  logic [CODE_W-1:0]   key_sparsity;
  logic                compression_ready;

  modport source (output valid, opcode, dim_m, dim_n, dim_k, job_sparsity, bucket_m,
                  bucket_n, bucket_k, key_dtype, key_sparsity, compression_ready,
                  input ready);
  modport sink (input valid, opcode, dim_m, dim_n, dim_k, job_sparsity, bucket_m,
                bucket_n, bucket_k, key_dtype, key_sparsity, compression_ready,
                output ready);
endinterface

interface sket_rsp_if;
  import sket_pkg::*;
  logic                valid;
  logic                ready;
  logic                eligible;
  logic [REASON_W-1:0] reason;
  logic                table_full;

  modport source (output valid, eligible, reason, table_full, input ready);
  modport sink (input valid, eligible, reason, table_full, output ready);
endinterface

interface sket_cfg_if;
  import sket_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [FLOPS_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/core/sparse_kernel_eligibility_table.sv
// Sparse kernel eligibility table: job checks and shape key failure tracking.
//
// channel | dir | carries
// req     | in  | opcode, job dims, job sparsity, shape key parts, compression flag
// rsp     | out | eligible, reason, table_full
// cfg     | in  | register index, write data (min_flops, failure_limit, two_four_code)
//
// Check and record requests pass from accept through two multiply steps, one tag read
// per entry through the single read port of the key RAM, the settling of the last
// compare, a decide step and the output load, which waits while a response still
// holds the output register; a key hit ends the scan early. Clear and unused
// opcodes go straight to the output load. Reset is synchronous and clears the
// valid bits at once; no clearing pass. A new request is accepted while a response
// still waits in the output register.
module sparse_kernel_eligibility_table #(
  parameter int TABLE_ENTRIES = 16,
  parameter int COUNT_WIDTH   = 8
) (
  input logic       clk,
  input logic       rst,
  sket_req_if.sink  req,
  sket_rsp_if.source rsp,
  sket_cfg_if.sink  cfg
);
  import sket_pkg::*;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int PTR_W = $clog2(TABLE_ENTRIES + 1);
  localparam int ROW_W = KEY_W + COUNT_WIDTH;
  localparam int CMP_W = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_WIDTH-1:0] COUNT_ONE = COUNT_WIDTH'(1);
  localparam logic [PTR_W-1:0]       PTR_END   = PTR_W'(TABLE_ENTRIES);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_MUL1   = 6'b000010,
    S_MUL2   = 6'b000100,
    S_SCAN   = 6'b001000,
    S_DECIDE = 6'b010000,
    S_FIN    = 6'b100000
  } state_t;

  state_t state;

  logic [FLOPS_W-1:0] min_flops;
  logic [LIMIT_W-1:0] failure_limit;
  logic [CODE_W-1:0]  two_four_code;

  opcode_t             op;
  logic [DIM_W-1:0]    dim_m;
  logic [DIM_W-1:0]    dim_n;
  logic [DIM_W-1:0]    dim_k;
  logic [CODE_W-1:0]   job_sparsity;
  key_t                key;
  logic                comp_ready;
  logic [PROD_MN_W-1:0] prod_mn;
  logic [PROD_W-1:0]   flops;

  logic [TABLE_ENTRIES-1:0] entry_valid;
  logic [PTR_W-1:0]         scan_ptr;
  logic                     cmp_v;
  logic [IDX_W-1:0]         cmp_idx;
  logic                     hit;
  logic [IDX_W-1:0]         hit_idx;
  logic [COUNT_WIDTH-1:0]   hit_cnt;
  logic                     free_found;
  logic [IDX_W-1:0]         free_idx;

  logic    res_eligible;
  reason_t res_reason;
  logic    res_full;
  logic    rsp_valid;
  logic    rsp_eligible;
  reason_t rsp_reason;
  logic    rsp_full;

  logic                   ram_we;
  logic [IDX_W-1:0]       ram_waddr;
  logic [ROW_W-1:0]       ram_wdata;
  logic                   ram_re;
  logic [ROW_W-1:0]       ram_rdata;
  key_t                   rd_key;
  logic [COUNT_WIDTH-1:0] rd_cnt;
  logic [IDX_W-1:0]       scan_idx;
  logic                   blacklisted;
  logic                   big_enough;
  logic [COUNT_WIDTH-1:0] cnt_inc;

  assign req.ready      = (state == S_IDLE);
  assign cfg.ready      = 1'b1;
  assign rsp.valid      = rsp_valid;
  assign rsp.eligible   = rsp_eligible;
  assign rsp.reason     = rsp_reason;
  assign rsp.table_full = rsp_full;

  assign rd_key   = ram_rdata[ROW_W-1:COUNT_WIDTH];
  assign rd_cnt   = ram_rdata[COUNT_WIDTH-1:0];
  assign scan_idx = scan_ptr[IDX_W-1:0];
  assign ram_re   = (state == S_SCAN) && (scan_ptr != PTR_END);

  assign blacklisted = hit && (CMP_W'(hit_cnt) >= CMP_W'(failure_limit));
  assign big_enough  = {flops, 1'b0} >= min_flops;
  assign cnt_inc     = (hit_cnt == COUNT_MAX) ? hit_cnt : hit_cnt + COUNT_ONE;

  assign ram_we    = (state == S_DECIDE) && (op == OP_RECORD) && (hit || free_found);
  assign ram_waddr = hit ? hit_idx : free_idx;
  assign ram_wdata = hit ? {key, cnt_inc} : {key, COUNT_ONE};

  sket_ram #(
    .WIDTH (ROW_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_tags (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (scan_idx),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      min_flops     <= MIN_FLOPS_RESET;
      failure_limit <= FAILURE_LIMIT_RESET;
      two_four_code <= TWO_FOUR_CODE_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_MIN_FLOPS:     min_flops     <= cfg.data;
        CFG_FAILURE_LIMIT: failure_limit <= cfg.data[LIMIT_W-1:0];
        CFG_TWO_FOUR_CODE: two_four_code <= cfg.data[CODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_valid <= '0;
      rsp_valid   <= 1'b0;
      cmp_v       <= 1'b0;
    end else begin
      if (state == S_FIN && (!rsp_valid || rsp.ready)) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            op           <= req.opcode;
            dim_m        <= req.dim_m;
            dim_n        <= req.dim_n;
            dim_k        <= req.dim_k;
            job_sparsity <= req.job_sparsity;
            key          <= {req.bucket_m, req.bucket_n, req.bucket_k,
                             req.key_dtype, req.key_sparsity};
            comp_ready   <= req.compression_ready;
            if (req.opcode == OP_CHECK || req.opcode == OP_RECORD) begin
              state <= S_MUL1;
            end else begin
              res_eligible <= 1'b0;
              res_reason   <= REASON_OK;
              res_full     <= 1'b0;
              if (req.opcode == OP_CLEAR) begin
                entry_valid <= '0;
              end
              state <= S_FIN;
            end
          end
        end
        S_MUL1: begin
          prod_mn <= PROD_MN_W'(dim_m) * PROD_MN_W'(dim_n);
          state   <= S_MUL2;
        end
        S_MUL2: begin
          flops      <= PROD_W'(prod_mn) * PROD_W'(dim_k);
          scan_ptr   <= '0;
          cmp_v      <= 1'b0;
          hit        <= 1'b0;
          free_found <= 1'b0;
          state      <= S_SCAN;
        end
        S_SCAN: begin
          if (cmp_v && rd_key == key) begin
            hit     <= 1'b1;
            hit_idx <= cmp_idx;
            hit_cnt <= rd_cnt;
            cmp_v   <= 1'b0;
            state   <= S_DECIDE;
          end else if (scan_ptr == PTR_END) begin
            cmp_v <= 1'b0;
            if (!cmp_v) begin
              state <= S_DECIDE;
            end
          end else begin
            cmp_v    <= entry_valid[scan_idx];
            cmp_idx  <= scan_idx;
            scan_ptr <= scan_ptr + PTR_W'(1);
            if (!entry_valid[scan_idx] && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= scan_idx;
            end
          end
        end
        S_DECIDE: begin
          if (op == OP_RECORD) begin
            res_eligible <= 1'b0;
            res_reason   <= REASON_OK;
            res_full     <= !hit && !free_found;
            if (!hit && free_found) begin
              entry_valid[free_idx] <= 1'b1;
            end
          end else begin
            res_full <= 1'b0;
            if (job_sparsity != two_four_code) begin
              res_eligible <= 1'b0;
              res_reason   <= REASON_WRONG_SPARSITY;
            end else if (!big_enough) begin
              res_eligible <= 1'b0;
              res_reason   <= REASON_TOO_SMALL;
            end else if (blacklisted) begin
              res_eligible <= 1'b0;
              res_reason   <= REASON_BLACKLISTED;
            end else if (!comp_ready) begin
              res_eligible <= 1'b0;
              res_reason   <= REASON_NO_COMPRESSION;
            end else begin
              res_eligible <= 1'b1;
              res_reason   <= REASON_OK;
            end
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_eligible <= res_eligible;
            rsp_reason   <= res_reason;
            rsp_full     <= res_full;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> state != S_IDLE)
    else $error("request accepted but sequencer stayed idle");

  a_ram_write_in_decide: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> state == S_DECIDE && op == OP_RECORD)
    else $error("key RAM written outside a record decision");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> scan_ptr <= PTR_END)
    else $error("scan pointer ran past the table");

  a_rsp_consistent: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(rsp.eligible && (rsp.reason != REASON_OK || rsp.table_full)))
    else $error("eligible response carries a reject reason or full flag");

endmodule

// File: rtl/core/sket_ram.sv
// Generic single-port-write, registered-read RAM.
module sket_ram #(
  parameter int WIDTH = 72,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
